@@ rtl/core/tss_pkg.sv @@
package tss_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_FLD_W  = 4;
    localparam int SLOTX_W     = (SLOT_W > SLOT_FLD_W) ? SLOT_W : SLOT_FLD_W;
    localparam int PRIO_W      = 7;
    localparam int COUNT_W     = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_SCHED  = 2'd3;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_DEAD  = 2'd3;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_DEAD_ADD = 2'd1;
    localparam logic [1:0] STATUS_REFUSED  = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [SLOT_FLD_W-1:0] slot;
        logic [PRIO_W-1:0]     priority_req;
        logic [COUNT_W-1:0]    start_count;
        logic [1:0]            task_state;
    } req_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_FLD_W-1:0] chosen_slot;
        logic                  recharged;
        logic [1:0]            status;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SET   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_SCHED = 3'd4
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  idx;
        logic [PRIO_W-1:0]  prio;
        logic [COUNT_W-1:0] cnt;
        logic [1:0]         st;
        logic [1:0]         status;
    } cmd_t;

endpackage

@@ rtl/core/task_slice_scheduler.sv @@
// task slot table with a priority time-slice scheduler
// req channel: req_valid / req_stall / req_data (req_t), one beat per request:
//   add task, set state, remove task or schedule
// rsp channel: rsp_valid / rsp_stall / rsp_data (rsp_t), exactly one beat
//   per request, in request order
// a front stage classifies each request into a two-entry command queue;
//   the back end owns the slot table and a result register
// add, set state and remove: front register, queue entry, result register;
//   the back end retires one per cycle when idle and no rsp beat is stalled
// schedule: the back end walks the table one slot per cycle, then sets the
//   result register; when the best count is zero, a second pass recharges
//   every valid slot to priority + count/2 while it picks again
// req_stall rises when the front stage holds a command and the queue is full
// a stalled rsp beat holds; the back end takes no new command until it leaves
// reset clears the slot table, the queue and the result register
module task_slice_scheduler (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tss_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tss_pkg::rsp_t rsp_data
);

    logic          push;
    tss_pkg::cmd_t push_cmd;
    logic          q_full;
    logic          head_valid;
    tss_pkg::cmd_t head_cmd;
    logic          pop;

    tss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full)
    );

    tss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    tss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule

@@ rtl/core/tss_front.sv @@
module tss_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tss_pkg::req_t req_data,
    output logic          push,
    output tss_pkg::cmd_t push_cmd,
    input  logic          q_full
);

    logic                          front_valid_reg;
    tss_pkg::cmd_t                 cmd_reg;
    tss_pkg::cmd_t                 cmd_next;
    logic [tss_pkg::SLOTX_W-1:0]   slot_x;
    logic                          in_range;
    logic                          accept;

    assign req_stall = front_valid_reg && q_full;
    assign accept    = req_valid && !req_stall;
    assign push      = front_valid_reg && !q_full;
    assign push_cmd  = cmd_reg;

    always_comb
    begin
        slot_x          = tss_pkg::SLOTX_W'(req_data.slot);
        in_range        = {1'b0, slot_x} < (tss_pkg::SLOTX_W + 1)'(tss_pkg::NUM_SLOTS);
        cmd_next.op     = tss_pkg::OP_NONE;
        cmd_next.idx    = slot_x[tss_pkg::SLOT_W-1:0];
        cmd_next.prio   = req_data.priority_req;
        cmd_next.cnt    = req_data.start_count;
        cmd_next.st     = req_data.task_state;
        cmd_next.status = tss_pkg::STATUS_DONE;
        unique case (req_data.req_type)
            tss_pkg::REQ_ADD:
            begin
                if (req_data.task_state == tss_pkg::ST_DEAD)
                begin
                    cmd_next.status = tss_pkg::STATUS_DEAD_ADD;
                end
                else if (in_range)
                begin
                    cmd_next.op = tss_pkg::OP_ADD;
                end
            end
            tss_pkg::REQ_SET:
            begin
                if (in_range)
                begin
                    cmd_next.op = tss_pkg::OP_SET;
                end
            end
            tss_pkg::REQ_REMOVE:
            begin
                // init task lives in slot 0
                if (req_data.slot == '0)
                begin
                    cmd_next.status = tss_pkg::STATUS_REFUSED;
                end
                else if (in_range)
                begin
                    cmd_next.op = tss_pkg::OP_CLEAR;
                end
            end
            tss_pkg::REQ_SCHED:
            begin
                cmd_next.op = tss_pkg::OP_SCHED;
            end
            default:
            begin
                cmd_next.op = tss_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            front_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            front_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ rtl/core/tss_queue.sv @@
module tss_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tss_pkg::cmd_t push_cmd,
    output logic          q_full,
    output logic          head_valid,
    output tss_pkg::cmd_t head_cmd,
    input  logic          pop
);

    tss_pkg::cmd_t                entry_reg [tss_pkg::QUEUE_DEPTH];
    logic [tss_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tss_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tss_pkg::QCNT_W-1:0]   fill_reg;
    logic                         do_pop;

    assign q_full     = fill_reg == tss_pkg::QCNT_W'(tss_pkg::QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == tss_pkg::QPTR_W'(tss_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == tss_pkg::QPTR_W'(tss_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/tss_back.sv @@
module tss_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  tss_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tss_pkg::rsp_t rsp_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } fsm_t;

    localparam logic [tss_pkg::SLOT_W-1:0] LAST_IDX = tss_pkg::SLOT_W'(tss_pkg::NUM_SLOTS - 1);

    fsm_t                          fsm_reg;
    logic                          slot_valid_reg [tss_pkg::NUM_SLOTS];
    logic [1:0]                    slot_state_reg [tss_pkg::NUM_SLOTS];
    logic [tss_pkg::PRIO_W-1:0]    slot_prio_reg  [tss_pkg::NUM_SLOTS];
    logic [tss_pkg::COUNT_W-1:0]   slot_count_reg [tss_pkg::NUM_SLOTS];

    logic [tss_pkg::SLOT_W-1:0]    idx_reg;
    logic                          pass2_reg;
    logic                          best_found_reg;
    logic [tss_pkg::SLOT_W-1:0]    best_idx_reg;
    logic [tss_pkg::COUNT_W-1:0]   best_cnt_reg;
    logic                          rsp_valid_reg;
    tss_pkg::rsp_t                 rsp_reg;

    logic                          rsp_free;
    logic                          take;
    logic [tss_pkg::COUNT_W-1:0]   rech_cnt;
    logic [tss_pkg::COUNT_W-1:0]   cur_cnt;
    logic                          cand;
    logic                          better;
    logic                          nb_found;
    logic [tss_pkg::SLOT_W-1:0]    nb_idx;
    logic [tss_pkg::COUNT_W-1:0]   nb_cnt;
    logic                          last;
    logic                          scan_end;
    logic                          start_pass2;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign take      = (fsm_reg == S_IDLE) && head_valid && rsp_free;
    assign pop       = take;

    always_comb
    begin
        rech_cnt = tss_pkg::COUNT_W'({1'b0, slot_prio_reg[idx_reg]})
                 + tss_pkg::COUNT_W'(slot_count_reg[idx_reg] >> 1);
        cur_cnt  = pass2_reg ? rech_cnt : slot_count_reg[idx_reg];
        cand     = slot_valid_reg[idx_reg] && (slot_state_reg[idx_reg] == tss_pkg::ST_READY);
        better   = cand && (!best_found_reg || (cur_cnt > best_cnt_reg));
        nb_found = best_found_reg || cand;
        nb_idx   = better ? idx_reg : best_idx_reg;
        nb_cnt   = better ? cur_cnt : best_cnt_reg;
        last     = idx_reg == LAST_IDX;
        scan_end = (fsm_reg == S_SCAN) && last;
        start_pass2 = scan_end && !pass2_reg && nb_found && (nb_cnt == '0);
    end

    // slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tss_pkg::NUM_SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
                slot_state_reg[i] <= '0;
                slot_prio_reg[i]  <= '0;
                slot_count_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            case (head_cmd.op)
                tss_pkg::OP_ADD:
                begin
                    slot_valid_reg[head_cmd.idx] <= 1'b1;
                    slot_state_reg[head_cmd.idx] <= head_cmd.st;
                    slot_prio_reg[head_cmd.idx]  <= head_cmd.prio;
                    slot_count_reg[head_cmd.idx] <= head_cmd.cnt;
                end
                tss_pkg::OP_SET:
                begin
                    if (slot_valid_reg[head_cmd.idx])
                    begin
                        slot_state_reg[head_cmd.idx] <= head_cmd.st;
                    end
                end
                tss_pkg::OP_CLEAR:
                begin
                    slot_valid_reg[head_cmd.idx] <= 1'b0;
                    slot_state_reg[head_cmd.idx] <= '0;
                    slot_prio_reg[head_cmd.idx]  <= '0;
                    slot_count_reg[head_cmd.idx] <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if ((fsm_reg == S_SCAN) && pass2_reg && slot_valid_reg[idx_reg])
        begin
            // recharge pass rewrites each valid slot's count as it is visited
            slot_count_reg[idx_reg] <= rech_cnt;
        end
    end

    // scan sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_IDLE;
            idx_reg        <= '0;
            pass2_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (fsm_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (head_cmd.op == tss_pkg::OP_SCHED)
                        begin
                            fsm_reg        <= S_SCAN;
                            idx_reg        <= '0;
                            pass2_reg      <= 1'b0;
                            best_found_reg <= 1'b0;
                        end
                        else
                        begin
                            rsp_valid_reg       <= 1'b1;
                            rsp_reg.found       <= 1'b0;
                            rsp_reg.chosen_slot <= '0;
                            rsp_reg.recharged   <= 1'b0;
                            rsp_reg.status      <= head_cmd.status;
                        end
                    end
                end
                S_SCAN:
                begin
                    best_found_reg <= nb_found;
                    best_idx_reg   <= nb_idx;
                    best_cnt_reg   <= nb_cnt;
                    idx_reg        <= last ? '0 : idx_reg + 1'b1;
                    if (start_pass2)
                    begin
                        pass2_reg      <= 1'b1;
                        best_found_reg <= 1'b0;
                    end
                    else if (scan_end)
                    begin
                        fsm_reg             <= S_IDLE;
                        rsp_valid_reg       <= 1'b1;
                        rsp_reg.found       <= nb_found;
                        rsp_reg.chosen_slot <= nb_found ? tss_pkg::SLOT_FLD_W'(nb_idx) : '0;
                        rsp_reg.recharged   <= nb_found && pass2_reg;
                        rsp_reg.status      <= tss_pkg::STATUS_DONE;
                    end
                end
                default:
                begin
                    fsm_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/tss_checker.sv @@
module tss_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input tss_pkg::req_t req_data,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input tss_pkg::rsp_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("rsp beat changed while stalled");

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != tss_pkg::STATUS_DONE)
        |-> !rsp_data.found && !rsp_data.recharged && (rsp_data.chosen_slot == '0))
        else $error("non-schedule result carries schedule fields");

    a_none_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.found |-> !rsp_data.recharged && (rsp_data.chosen_slot == '0))
        else $error("empty schedule result carries a slot or recharge");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
        else $error("req beat changed while stalled");

endmodule

bind task_slice_scheduler tss_checker u_tss_checker (.*);
